// ----- hdl/kdar_pkg.sv -----
// ----------------------------------------------------------------------------
// kdar_pkg
// Shared constants and types of the key debounce / auto-repeat unit.
// ----------------------------------------------------------------------------
package kdar_pkg;

	// Number of debounced keys; the raw level field carries IN_KEYS of them.
	localparam int NUM_KEYS  = 4;
	localparam int IN_KEYS   = 4;
	localparam int SEL_W     = 3;
	localparam int CNT_W     = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// Repeat count markers left behind by the first press pulse.
	localparam logic [CNT_W-1:0] MARK_PLAIN  = 8'hFF;
	localparam logic [CNT_W-1:0] MARK_REPEAT = 8'hFE;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REP_ENABLE = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [CNT_W-1:0]   RST_DEBOUNCE   = 8'd5;
	localparam logic [CNT_W-1:0]   RST_HOLD_DELAY = 8'd100;
	localparam logic [CNT_W-1:0]   RST_REPEAT     = 8'd20;
	localparam logic [IN_KEYS-1:0] RST_REP_ENABLE = '0;

	// Thresholds shared by every lane.
	typedef struct packed {
		logic [CNT_W-1:0] debounce_ticks;
		logic [CNT_W-1:0] hold_delay_ticks;
		logic [CNT_W-1:0] repeat_ticks;
	} kdar_thr_t;

	// What one lane reports to the merge stage for the accepted tick.
	typedef struct packed {
		logic pulse;
		logic held;
	} kdar_lane_st_t;

endpackage

// ----- hdl/kdar_if.sv -----
// ----------------------------------------------------------------------------
// kdar channel interfaces
// Valid/ready channels of the key unit: key levels in, results out, config.
// ----------------------------------------------------------------------------
interface kdar_key_if;
	logic                          valid;
	logic                          ready;
	logic [kdar_pkg::IN_KEYS-1:0]  key_levels;

	modport source (output valid, output key_levels, input ready);
	modport sink   (input valid, input key_levels, output ready);
endinterface

interface kdar_res_if;
	logic                          valid;
	logic                          ready;
	logic [kdar_pkg::SEL_W-1:0]    selected_key;
	logic [kdar_pkg::IN_KEYS-1:0]  pulse_bits;

	modport source (output valid, output selected_key, output pulse_bits, input ready);
	modport sink   (input valid, input selected_key, input pulse_bits, output ready);
endinterface

interface kdar_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [kdar_pkg::CFG_IDX_W-1:0]  index;
	logic [kdar_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/kdar_lane.sv -----
// ----------------------------------------------------------------------------
// kdar_lane
// Debounce and auto-repeat state of one key, stepped once per accepted tick.
// ----------------------------------------------------------------------------
module kdar_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 pressed,
	input  logic                 rep,
	input  kdar_pkg::kdar_thr_t  thr,
	output kdar_pkg::kdar_lane_st_t st_next
);
	import kdar_pkg::*;

	logic             held_q, pulse_q, hold_q;
	logic [CNT_W-1:0] settle_q, rcount_q;

	logic             held_d, pulse_d, hold_d;
	logic [CNT_W-1:0] settle_d, rcount_d;

	logic [CNT_W:0]   settle_inc;
	logic [CNT_W-1:0] rc1, rc2;
	logic             h1;

	// Next state of the key for this tick
	always_comb begin
		held_d     = held_q;
		pulse_d    = pulse_q;
		hold_d     = hold_q;
		settle_d   = settle_q;
		rcount_d   = rcount_q;
		settle_inc = {1'b0, settle_q} + 1'b1;
		rc1        = rcount_q;
		h1         = hold_q;
		rc2        = rc1 + 1'b1;
		if (!pressed) begin
			held_d   = 1'b0;
			pulse_d  = 1'b0;
			hold_d   = 1'b0;
			settle_d = '0;
			rcount_d = '0;
		end else if (!held_q) begin
			// first pressed tick
			held_d   = 1'b1;
			hold_d   = 1'b0;
			settle_d = '0;
			rcount_d = '0;
		end else if (!pulse_q && rcount_q == '0) begin
			// debounce phase
			if (settle_inc >= {1'b0, thr.debounce_ticks}) begin
				settle_d = thr.debounce_ticks;
				pulse_d  = 1'b1;
				rcount_d = rep ? MARK_REPEAT : MARK_PLAIN;
			end else begin
				settle_d = settle_inc[CNT_W-1:0];
			end
		end else if (!pulse_q) begin
			// hold delay, then repeat phase
			if (rep && rcount_q == MARK_PLAIN) begin
				rc1 = {{(CNT_W-1){1'b0}}, 1'b1};
			end else if (rep && !hold_q) begin
				rc1 = rcount_q + 1'b1;
				if (rc1 >= thr.hold_delay_ticks)
					h1 = 1'b1;
			end
			rc2    = rc1 + 1'b1;
			hold_d = h1;
			if (h1 && rep && rc1 != '0) begin
				if (rc2 >= thr.repeat_ticks) begin
					rcount_d = '0;
					pulse_d  = 1'b1;
				end else begin
					rcount_d = rc2;
				end
			end else begin
				rcount_d = rc1;
			end
		end else begin
			// pulse lasts one tick
			pulse_d = 1'b0;
			if (rep)
				rcount_d = rcount_q + 1'b1;
		end
	end

	assign st_next.pulse = pulse_d;
	assign st_next.held  = held_d;

	// Key state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			pulse_q  <= 1'b0;
			hold_q   <= 1'b0;
			settle_q <= '0;
			rcount_q <= '0;
		end else if (advance) begin
			held_q   <= held_d;
			pulse_q  <= pulse_d;
			hold_q   <= hold_d;
			settle_q <= settle_d;
			rcount_q <= rcount_d;
		end
	end

	// A released key holds no leftover state
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		!held_q |-> (!pulse_q && !hold_q && settle_q == '0 && rcount_q == '0))
		else $error("kdar_lane: state left on released key");

	// A released tick always clears the key
	a_release_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !pressed) |=> !held_q)
		else $error("kdar_lane: release did not clear key");

	// Pulse never lasts two accepted ticks in a row
	a_pulse_single: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && pulse_q) |-> !pulse_d)
		else $error("kdar_lane: pulse held over two ticks");

endmodule

// ----- hdl/kdar_merge.sv -----
// ----------------------------------------------------------------------------
// kdar_merge
// Priority-encodes the lane pulses and holds results in an output/skid pair.
// ----------------------------------------------------------------------------
module kdar_merge (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       push,
	input  kdar_pkg::kdar_lane_st_t [kdar_pkg::NUM_KEYS-1:0] lane_st,
	output logic                                       can_push,
	kdar_res_if.source                                 result
);
	import kdar_pkg::*;

	logic [SEL_W-1:0]   sel;
	logic [IN_KEYS-1:0] bits;

	logic               out_valid_s1, skid_valid_q;
	logic [SEL_W-1:0]   out_sel_s1, skid_sel_q;
	logic [IN_KEYS-1:0] out_bits_s1, skid_bits_q;
	logic               pop;

	// Lowest-numbered pulsing key wins
	always_comb begin
		sel  = SEL_W'(NUM_KEYS);
		bits = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (lane_st[k].pulse) begin
				sel = SEL_W'(k);
				if (k < IN_KEYS)
					bits[k] = 1'b1;
			end
		end
	end

	assign pop      = out_valid_s1 && result.ready;
	assign can_push = !skid_valid_q;

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_s1 || pop) begin
			if (skid_valid_q) begin
				out_valid_s1 <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_s1 <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_s1 || pop) begin
			if (skid_valid_q) begin
				out_sel_s1  <= skid_sel_q;
				out_bits_s1 <= skid_bits_q;
			end else begin
				out_sel_s1  <= sel;
				out_bits_s1 <= bits;
			end
		end else if (push) begin
			skid_sel_q  <= sel;
			skid_bits_q <= bits;
		end
	end

	assign result.valid        = out_valid_s1;
	assign result.selected_key = out_sel_s1;
	assign result.pulse_bits   = out_bits_s1;

	// Skid entry is only used behind a full output register
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_s1)
		else $error("kdar_merge: skid holds data with empty output");

	// No pulse means the none code
	a_none_code: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s1 && out_bits_s1 == '0) |-> out_sel_s1 == SEL_W'(NUM_KEYS))
		else $error("kdar_merge: key selected without pulse");

	// Never push into a full pair
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push && skid_valid_q) |-> 1'b0)
		else $error("kdar_merge: transaction pushed into full buffer");

endmodule

// ----- hdl/key_debounce_auto_repeat_unit.sv -----
// ----------------------------------------------------------------------------
// key_debounce_auto_repeat_unit
// Debounces four keys with per-key auto-repeat and reports the pulsing keys.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                           Transaction
// key_in   in   key_levels[3:0]                   one scan tick
// result   out  selected_key[2:0], pulse_bits[3:0] one result per tick
// cfg      in   index[1:0], data[7:0]             one register write
//
// One tick is taken every cycle while the skid entry is empty; its result
// is registered in the output register, or in the skid entry behind it
// while result is stalled, so key_in keeps flowing; ready drops only
// when both are full. Config writes are taken every cycle.
// Reset loads the register defaults and clears all key state.
// ----------------------------------------------------------------------------
module key_debounce_auto_repeat_unit (
	input  logic        clk,
	input  logic        arst_n,
	kdar_key_if.sink    key_in,
	kdar_res_if.source  result,
	kdar_cfg_if.sink    cfg
);
	import kdar_pkg::*;

	kdar_thr_t                         thr_q;
	logic [IN_KEYS-1:0]                rep_en_q;
	kdar_lane_st_t [NUM_KEYS-1:0]      lane_st;
	logic                              can_push;
	logic                              advance;

	assign key_in.ready = can_push;
	assign advance      = key_in.valid && can_push;
	assign cfg.ready    = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.debounce_ticks   <= RST_DEBOUNCE;
			thr_q.hold_delay_ticks <= RST_HOLD_DELAY;
			thr_q.repeat_ticks     <= RST_REPEAT;
			rep_en_q               <= RST_REP_ENABLE;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEBOUNCE:   thr_q.debounce_ticks   <= cfg.data;
				REG_HOLD_DELAY: thr_q.hold_delay_ticks <= cfg.data;
				REG_REPEAT:     thr_q.repeat_ticks     <= cfg.data;
				REG_REP_ENABLE: rep_en_q               <= cfg.data[IN_KEYS-1:0];
				default: ;
			endcase
		end
	end

	// One lane per key; keys past the input width read as released
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic pressed, rep;
		if (k < IN_KEYS) begin : g_live
			assign pressed = key_in.key_levels[k];
			assign rep     = rep_en_q[k];
		end else begin : g_dead
			assign pressed = 1'b0;
			assign rep     = 1'b0;
		end
		kdar_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.pressed (pressed),
			.rep     (rep),
			.thr     (thr_q),
			.st_next (lane_st[k])
		);
	end

	kdar_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.lane_st  (lane_st),
		.can_push (can_push),
		.result   (result)
	);

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key debounce / auto-repeat unit. Scan ticks are
// queued by the sequencer, sent by a clocked driver, and predicted per key on
// acceptance. A clocked monitor checks every result in order. Phases change
// the thresholds, the repeat mask and the amount of idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import kdar_pkg::*;

	// Per-key debounce/repeat state kept by the predictor.
	typedef struct packed {
		logic             held;
		logic             pulse;
		logic [CNT_W-1:0] settle;
		logic [CNT_W-1:0] rcount;
		logic             hold;
	} lane_t;

	typedef struct packed {
		logic [SEL_W-1:0]   sel;
		logic [IN_KEYS-1:0] pulses;
	} key_report_t;

	typedef enum {GAP_NONE, GAP_SENDER, GAP_RECEIVER, GAP_BOTH} gap_mode_t;

	logic clk;
	logic arst_n;

	kdar_key_if key_ch();
	kdar_res_if res_ch();
	kdar_cfg_if cfg_ch();

	key_debounce_auto_repeat_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.key_in (key_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state and its copy of the registers
	lane_t              lanes [NUM_KEYS];
	logic [CNT_W-1:0]   cfg_debounce;
	logic [CNT_W-1:0]   cfg_hold_delay;
	logic [CNT_W-1:0]   cfg_repeat;
	logic [IN_KEYS-1:0] cfg_rep_en;

	logic [IN_KEYS-1:0] tick_q [$];
	key_report_t        report_q [$];
	logic [IN_KEYS-1:0] last_level;
	gap_mode_t          gap_mode;
	int                 squeeze_left;
	int                 mismatches;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance every key by one scan tick and queue the expected result
	function automatic void scan_tick(input logic [IN_KEYS-1:0] levels);
		lane_t       ln;
		logic [CNT_W:0] bumped;
		logic        pressed;
		logic        rep;
		key_report_t rpt;
		for (int k = 0; k < NUM_KEYS; k++) begin
			pressed = (k < IN_KEYS) ? levels[k] : 1'b0;
			rep     = (k < IN_KEYS) ? cfg_rep_en[k] : 1'b0;
			ln      = lanes[k];
			if (!pressed) begin
				ln = '0;
			end else if (!ln.held) begin
				// first pressed tick only arms the key
				ln.held   = 1'b1;
				ln.settle = '0;
				ln.rcount = '0;
				ln.hold   = 1'b0;
			end else if (!ln.pulse && ln.rcount == '0) begin
				// debounce: settle count clamps at the threshold
				bumped = {1'b0, ln.settle} + 1'b1;
				if (bumped >= {1'b0, cfg_debounce}) begin
					ln.settle = cfg_debounce;
					ln.pulse  = 1'b1;
					ln.rcount = rep ? MARK_REPEAT : MARK_PLAIN;
				end else begin
					ln.settle = bumped[CNT_W-1:0];
				end
			end else if (!ln.pulse) begin
				if (rep && ln.rcount == MARK_PLAIN) begin
					ln.rcount = CNT_W'(1);
				end else if (rep && !ln.hold) begin
					ln.rcount = ln.rcount + 1'b1;
					if (ln.rcount >= cfg_hold_delay)
						ln.hold = 1'b1;
				end
				// repeat phase steps again on the tick it starts
				if (ln.hold && rep && ln.rcount != '0) begin
					ln.rcount = ln.rcount + 1'b1;
					if (ln.rcount >= cfg_repeat) begin
						ln.rcount = '0;
						ln.pulse  = 1'b1;
					end
				end
			end else begin
				ln.pulse = 1'b0;
				if (rep)
					ln.rcount = ln.rcount + 1'b1;
			end
			lanes[k] = ln;
		end
		// priority encode, key 0 wins
		rpt.sel    = SEL_W'(NUM_KEYS);
		rpt.pulses = '0;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (lanes[k].pulse) begin
				rpt.sel = SEL_W'(k);
				if (k < IN_KEYS)
					rpt.pulses[k] = 1'b1;
			end
		end
		report_q.push_back(rpt);
	endfunction

	// Write all four registers back to back, valid held high between them
	task automatic write_settings(input logic [CNT_W-1:0] deb, input logic [CNT_W-1:0] hd,
			input logic [CNT_W-1:0] rp, input logic [CFG_DAT_W-1:0] en_data);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [CFG_DAT_W-1:0] val [4];
		idx[0] = REG_DEBOUNCE;   val[0] = deb;
		idx[1] = REG_HOLD_DELAY; val[1] = hd;
		idx[2] = REG_REPEAT;     val[2] = rp;
		idx[3] = REG_REP_ENABLE; val[3] = en_data;
		@(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= idx[i];
			cfg_ch.data  <= val[i];
			do @(posedge clk); while (!cfg_ch.ready);
			case (idx[i])
				REG_DEBOUNCE:   cfg_debounce   = val[i];
				REG_HOLD_DELAY: cfg_hold_delay = val[i];
				REG_REPEAT:     cfg_repeat     = val[i];
				REG_REP_ENABLE: cfg_rep_en     = val[i][IN_KEYS-1:0];
				default: ;
			endcase
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// Queue held-key segments with random content and the odd bouncing bit;
	// the first segment continues whatever was held at the end of the last phase
	task automatic queue_ticks(input int count, input int max_len);
		int                 made;
		int                 len;
		logic [IN_KEYS-1:0] lvl;
		made = 0;
		while (made < count) begin
			len = $urandom_range(1, max_len);
			for (int i = 0; i < len && made < count; i++) begin
				lvl = last_level;
				if ($urandom_range(0, 19) == 0)
					lvl[$urandom_range(0, IN_KEYS - 1)] ^= 1'b1;
				tick_q.push_back(lvl);
				made++;
			end
			if (made < count)
				last_level = IN_KEYS'($urandom_range(0, 15));
		end
	endtask

	// Block until every queued tick is sent and every result has come back
	task automatic wait_drained();
		while (tick_q.size() != 0 || key_ch.valid || report_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Driver: offer the oldest pending tick, predict it on acceptance
	always @(posedge clk) begin : drive_ticks
		logic accepted;
		logic idle;
		if (arst_n) begin
			accepted = key_ch.valid && key_ch.ready;
			if (accepted) begin
				scan_tick(key_ch.key_levels);
				void'(tick_q.pop_front());
			end
			case (gap_mode)
				GAP_SENDER: idle = ($urandom_range(0, 99) < 66);
				GAP_BOTH:   idle = ($urandom_range(0, 99) < 15);
				default:    idle = 1'b0;
			endcase
			if (key_ch.valid && !accepted) begin
				// hold the offered tick
			end else if (tick_q.size() != 0 && !idle) begin
				key_ch.valid      <= 1'b1;
				key_ch.key_levels <= tick_q[0];
			end else begin
				key_ch.valid      <= 1'b0;
				key_ch.key_levels <= IN_KEYS'($urandom_range(0, 15));
			end
		end
	end

	// Long receiver hold-off, counted down once armed by the sequencer
	always @(posedge clk) begin
		if (squeeze_left != 0)
			squeeze_left <= squeeze_left - 1;
	end

	// Monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		key_report_t want;
		logic        stall;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (report_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual sel %0d pulses %b",
					$time, res_ch.selected_key, res_ch.pulse_bits);
				mismatches++;
			end else begin
				want = report_q.pop_front();
				if (res_ch.selected_key !== want.sel) begin
					$display("%0t: selected_key expected %0d, actual %0d",
						$time, want.sel, res_ch.selected_key);
					mismatches++;
				end
				if (res_ch.pulse_bits !== want.pulses) begin
					$display("%0t: pulse_bits expected %b, actual %b",
						$time, want.pulses, res_ch.pulse_bits);
					mismatches++;
				end
			end
		end
		case (gap_mode)
			GAP_RECEIVER: stall = ($urandom_range(0, 99) < 66);
			GAP_BOTH:     stall = ($urandom_range(0, 99) < 15);
			default:      stall = 1'b0;
		endcase
		res_ch.ready <= (squeeze_left == 0) && !stall;
	end

	// Sequencer: reset, directed ticks, then randomized phases
	initial begin
		logic [IN_KEYS-1:0]   opening [25];
		logic [CNT_W-1:0]     corner_vals [5];
		logic [CNT_W-1:0]     deb;
		logic [CNT_W-1:0]     hd;
		logic [CNT_W-1:0]     rp;
		logic [IN_KEYS-1:0]   en;
		opening = '{4'h0, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF,
			4'h8, 4'h8, 4'h0, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5, 4'h5,
			4'hA, 4'hA, 4'h1, 4'h2, 4'h4, 4'h8};
		corner_vals = '{8'd0, 8'd1, 8'd253, 8'd254, 8'd255};

		arst_n            = 1'b0;
		key_ch.valid      = 1'b0;
		key_ch.key_levels = '0;
		res_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		squeeze_left      = 0;
		mismatches        = 0;
		gap_mode          = GAP_NONE;
		last_level        = '0;
		cfg_debounce      = RST_DEBOUNCE;
		cfg_hold_delay    = RST_HOLD_DELAY;
		cfg_repeat        = RST_REPEAT;
		cfg_rep_en        = RST_REP_ENABLE;
		for (int k = 0; k < NUM_KEYS; k++)
			lanes[k] = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed ticks at the reset thresholds
		for (int i = 0; i < 25; i++)
			tick_q.push_back(opening[i]);
		last_level = opening[24];
		wait_drained();

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: begin deb = 8'd1; hd = 8'd1; rp = 8'd1; en = 4'hF; end
				1: begin
					deb = 8'd0; hd = 8'd0; rp = 8'd0;
					en = IN_KEYS'($urandom_range(0, 15));
				end
				// top of range: repeat count wraps past 0xFF
				2: begin deb = 8'd254; hd = 8'd255; rp = 8'd255; en = 4'b0101; end
				default: begin
					deb = ($urandom_range(0, 3) == 0) ? corner_vals[$urandom_range(0, 4)]
						: CNT_W'($urandom_range(1, 6));
					hd  = ($urandom_range(0, 3) == 0) ? corner_vals[$urandom_range(0, 4)]
						: CNT_W'($urandom_range(1, 20));
					rp  = ($urandom_range(0, 3) == 0) ? corner_vals[$urandom_range(0, 4)]
						: CNT_W'($urandom_range(1, 10));
					en  = IN_KEYS'($urandom_range(0, 15));
				end
			endcase
			write_settings(deb, hd, rp, {4'($urandom_range(0, 15)), en});
			@(negedge clk);
			gap_mode = gap_mode_t'(p % 4);
			if (p == 4)
				squeeze_left = 80;
			if (p == 2) begin
				last_level = 4'hF;
				queue_ticks(560, 560);
				queue_ticks(40, 20);
			end else begin
				queue_ticks(120, $urandom_range(4, 60));
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/kdar_pkg.sv
hdl/kdar_if.sv
hdl/kdar_lane.sv
hdl/kdar_merge.sv
hdl/key_debounce_auto_repeat_unit.sv
verif/testbench.sv
